>>> rtl/core/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, with a disable condition.
`define ZSMA_ASSERT_IMP(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, with a disable condition.
`define ZSMA_ASSERT_NXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/zsma_pkg.sv
`timescale 1ns / 1ps

package zsma_pkg;

    // window geometry
    localparam int WINDOW_SIZE = 5;
    localparam int HALF_SPAN   = WINDOW_SIZE / 2;
    localparam int LINE_DEPTH  = 2 * HALF_SPAN + 1;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 12;
    localparam int BOUND_W    = POS_W + 1;
    localparam int DROP_W     = 8;
    localparam int MINV_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int OFS_W  = $clog2(HALF_SPAN + 1);
    localparam int LAG_W  = $clog2(LINE_DEPTH);
    localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(LINE_DEPTH);
    localparam int MAG_W  = SUM_W - 1;

    // reciprocal divide: q0 = (mag * floor(2^SH / n)) >> SH, off by at most one
    localparam int RECIP_SH  = MAG_W + 2;
    localparam int RECIP_W   = RECIP_SH + 1;
    localparam int PROD_W    = MAG_W + RECIP_W;
    localparam int RECIP_ONE = 1 << RECIP_SH;

    // job queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // register reset values
    localparam logic [POS_W-1:0]  RST_FRAME_LEN  = 12'd1200;
    localparam logic [DROP_W-1:0] RST_DROP_COUNT = 8'd15;
    localparam logic [POS_W-1:0]  RST_BLOCK_LEN  = 12'd250;
    localparam logic [MINV_W-1:0] RST_MIN_VALID  = 3'd3;

    localparam int RST_START_I = (int'(RST_DROP_COUNT) < int'(RST_FRAME_LEN))
                                 ? int'(RST_DROP_COUNT) : int'(RST_FRAME_LEN);
    localparam int RST_STOP_I  = (RST_START_I + int'(RST_BLOCK_LEN) > int'(RST_FRAME_LEN))
                                 ? int'(RST_FRAME_LEN) : RST_START_I + int'(RST_BLOCK_LEN);
    localparam logic [BOUND_W-1:0] RST_BND_START = BOUND_W'(RST_START_I);
    localparam logic [BOUND_W-1:0] RST_BND_STOP  = BOUND_W'(RST_STOP_I);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_LEN  = 2'd0,
        REG_DROP_COUNT = 2'd1,
        REG_BLOCK_LEN  = 2'd2,
        REG_MIN_VALID  = 2'd3
    } cfg_reg_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic [POS_W-1:0]  frame_len;
        logic [DROP_W-1:0] drop_count;
        logic [POS_W-1:0]  block_len;
        logic [MINV_W-1:0] min_valid;
    } cfg_t;

    // one classified sample: window snapshot and the positions it settles
    typedef struct packed {
        sample_t [LINE_DEPTH-1:0] line;      // index 0 newest
        logic [POS_W-1:0]         newest;
        logic [POS_W-1:0]         first_pos;
        logic [OFS_W-1:0]         last_ofs;
        logic                     frame_end;
    } job_t;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            1:       r = RECIP_W'(RECIP_ONE / 1);
            2:       r = RECIP_W'(RECIP_ONE / 2);
            3:       r = RECIP_W'(RECIP_ONE / 3);
            4:       r = RECIP_W'(RECIP_ONE / 4);
            5:       r = RECIP_W'(RECIP_ONE / 5);
            6:       r = RECIP_W'(RECIP_ONE / 6);
            7:       r = RECIP_W'(RECIP_ONE / 7);
            8:       r = RECIP_W'(RECIP_ONE / 8);
            9:       r = RECIP_W'(RECIP_ONE / 9);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/zsma_queue.sv
`timescale 1ns / 1ps

module zsma_queue import zsma_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_data,
    input  logic pop,
    output job_t pop_data,
    output logic full,
    output logic not_empty
);

    job_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   fill_reg, fill_next;

    assign full      = (fill_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/zsma_front.sv
`timescale 1ns / 1ps

module zsma_front import zsma_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_sample,
    input  logic                q_full,
    output logic                q_push,
    output job_t                q_data,
    output logic                idx_zero
);

    sample_t [LINE_DEPTH-1:0] line_reg, line_next;
    logic [POS_W-1:0]         idx_reg, idx_next;
    logic [POS_W:0]           idx_inc;
    logic [POS_W-1:0]         first_pos, ofs_diff;
    logic                     frame_end, accept, has_work;

    always_comb begin
        accept    = s_tvalid && !q_full;
        idx_inc   = (POS_W + 1)'(idx_reg) + (POS_W + 1)'(1);
        frame_end = (idx_inc >= {1'b0, cfg.frame_len});
        line_next = {line_reg[LINE_DEPTH-2:0], sample_t'(s_sample)};

        // normal step settles the sample HALF_SPAN back; frame end flushes the rest
        if (frame_end) begin
            first_pos = (idx_reg >= POS_W'(HALF_SPAN)) ? idx_reg - POS_W'(HALF_SPAN) : '0;
        end else begin
            first_pos = idx_reg - POS_W'(HALF_SPAN);
        end
        ofs_diff = frame_end ? idx_reg - first_pos : '0;
        has_work = frame_end || (idx_reg >= POS_W'(HALF_SPAN));
        idx_next = frame_end ? '0 : idx_inc[POS_W-1:0];
    end

    assign s_tready           = !q_full;
    assign q_push             = accept && has_work;
    assign q_data.line        = line_next;
    assign q_data.newest      = idx_reg;
    assign q_data.first_pos   = first_pos;
    assign q_data.last_ofs    = ofs_diff[OFS_W-1:0];
    assign q_data.frame_end   = frame_end;
    assign idx_zero           = (idx_reg == '0);

    always_ff @(posedge aclk) begin
        if (accept) begin
            line_reg <= line_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (accept) begin
            idx_reg <= idx_next;
        end
    end

endmodule

>>> rtl/core/zsma_back.sv
`timescale 1ns / 1ps

module zsma_back import zsma_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                cfg_upd,
    input  logic                idx_zero,
    input  job_t                job,
    input  logic                job_valid,
    output logic                job_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_filtered,
    output logic [POS_W-1:0]    m_position,
    output logic                m_tlast
);

    typedef struct packed {
        logic                     valid;
        logic                     fin;       // last position of its job
        logic [POS_W-1:0]         pos;
        logic [POS_W-1:0]         newest;
        logic [BOUND_W-1:0]       start;
        logic [BOUND_W-1:0]       stop;
        sample_t [LINE_DEPTH-1:0] line;
    } chk_t;

    typedef struct packed {
        logic                     valid;
        logic                     fire;
        logic                     fin;
        logic [POS_W-1:0]         pos;
        sample_t                  raw;
        logic signed [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]         cnt;
        logic [MAG_W-1:0]         mag;
        logic                     neg;
        logic                     use_avg;
        logic [MAG_W-1:0]         quo;
    } tok_t;

    localparam int REM_W = MAG_W + CNT_W;

    // bound sequencer: one position a cycle while a job waits and the hold stage can advance
    logic [OFS_W-1:0]   ofs_reg;
    logic [BOUND_W-1:0] start_reg, stop_reg;
    logic [BOUND_W-1:0] fl13, drop13, fb_start, fb_sum, fb_stop;
    logic [BOUND_W-1:0] adv_sum, adv_start, tok_start, tok_sum, tok_stop;
    logic [POS_W-1:0]   cur_pos;
    logic               need_adv, issue, job_last, adv;

    always_comb begin
        fl13     = BOUND_W'(cfg.frame_len);
        drop13   = BOUND_W'(cfg.drop_count);
        fb_start = (drop13 < fl13) ? drop13 : fl13;
        fb_sum   = fb_start + BOUND_W'(cfg.block_len);
        fb_stop  = (fb_sum > fl13) ? fl13 : fb_sum;

        cur_pos   = job.first_pos + POS_W'(ofs_reg);
        need_adv  = ({1'b0, cur_pos} >= stop_reg);
        adv_sum   = stop_reg + drop13;
        adv_start = (adv_sum > fl13) ? fl13 : adv_sum;
        tok_start = need_adv ? adv_start : start_reg;
        tok_sum   = tok_start + BOUND_W'(cfg.block_len);
        tok_stop  = need_adv ? ((tok_sum > fl13) ? fl13 : tok_sum) : stop_reg;

        issue    = adv && job_valid;
        job_last = (ofs_reg == job.last_ofs);
    end

    assign job_pop = issue && job_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ofs_reg   <= '0;
            start_reg <= RST_BND_START;
            stop_reg  <= RST_BND_STOP;
        end else if (cfg_upd && idx_zero) begin
            start_reg <= fb_start;
            stop_reg  <= fb_stop;
        end else if (issue) begin
            if (job_last) begin
                ofs_reg <= '0;
                // frame end: next job starts a fresh frame
                start_reg <= job.frame_end ? fb_start : tok_start;
                stop_reg  <= job.frame_end ? fb_stop  : tok_stop;
            end else begin
                ofs_reg   <= ofs_reg + 1'b1;
                start_reg <= tok_start;
                stop_reg  <= tok_stop;
            end
        end
    end

    // ---------------- check stage: keep decision, window sum ----------------
    chk_t                    c_reg;
    tok_t                    d_reg, e_reg, f_reg, g_reg;
    tok_t                    d_next, e_next, f_next, g_next;
    logic [POS_W-1:0]        lag;
    logic [LAG_W-1:0]        lag_i;
    logic [BOUND_W-1:0]      span, keep_end, pos13;
    logic signed [SUM_W-1:0] sum_acc;
    logic [CNT_W-1:0]        cnt_acc;
    logic                    in_win;

    always_comb begin
        lag      = c_reg.newest - c_reg.pos;
        lag_i    = lag[LAG_W-1:0];
        pos13    = {1'b0, c_reg.pos};
        span     = c_reg.stop - c_reg.start;
        keep_end = (span > drop13) ? c_reg.stop - drop13 : c_reg.start;

        sum_acc = '0;
        cnt_acc = '0;
        for (int k = 0; k < LINE_DEPTH; k++) begin
            in_win = (POS_W'(k) <= c_reg.newest) && (k <= int'(lag_i) + HALF_SPAN)
                     && (k + HALF_SPAN >= int'(lag_i));
            if (in_win && (c_reg.line[k] != '0)) begin
                sum_acc = sum_acc + SUM_W'(c_reg.line[k]);
                cnt_acc = cnt_acc + CNT_W'(1);
            end
        end

        d_next         = '0;
        d_next.valid   = c_reg.valid;
        d_next.fin     = c_reg.fin;
        d_next.pos     = c_reg.pos;
        d_next.raw     = c_reg.line[lag_i];
        d_next.sum     = sum_acc;
        d_next.cnt     = cnt_acc;
        d_next.fire    = c_reg.valid && (pos13 >= c_reg.start) && (pos13 < keep_end)
                         && (c_reg.line[lag_i] != '0);
    end

    // ---------------- magnitude, divide, sign ----------------
    logic [PROD_W-1:0] prod;
    logic [REM_W-1:0]  back_prod, rem;
    logic [MAG_W:0]    quo_ext;
    logic [SAMPLE_W:0] avg_w;
    sample_t           tok_val;

    always_comb begin
        e_next         = d_reg;
        e_next.neg     = d_reg.sum[SUM_W-1];
        e_next.mag     = d_reg.sum[SUM_W-1] ? MAG_W'(-d_reg.sum) : MAG_W'(d_reg.sum);
        e_next.use_avg = (d_reg.cnt != '0) && (int'(d_reg.cnt) >= int'(cfg.min_valid));

        prod       = PROD_W'(e_reg.mag) * PROD_W'(recip_of(e_reg.cnt));
        f_next     = e_reg;
        f_next.quo = prod[RECIP_SH +: MAG_W];

        // reciprocal estimate is low by at most one
        back_prod  = REM_W'(f_reg.quo) * REM_W'(f_reg.cnt);
        rem        = REM_W'(f_reg.mag) - back_prod;
        g_next     = f_reg;
        g_next.quo = (rem >= REM_W'(f_reg.cnt)) ? f_reg.quo + 1'b1 : f_reg.quo;

        quo_ext = {1'b0, g_reg.quo};
        avg_w   = g_reg.neg ? (SAMPLE_W + 1)'(-quo_ext) : (SAMPLE_W + 1)'(quo_ext);
        tok_val = g_reg.use_avg ? sample_t'(avg_w[SAMPLE_W-1:0]) : g_reg.raw;
    end

    // ---------------- hold and output register ----------------
    logic                hold_valid_reg, hold_fin_reg;
    sample_t             hold_val_reg;
    logic [POS_W-1:0]    hold_pos_reg;
    logic                out_valid_reg, out_last_reg;
    sample_t             out_val_reg;
    logic [POS_W-1:0]    out_pos_reg;
    logic                o_free, tok_out, tok_end, hold_mv, hold_last;

    always_comb begin
        o_free    = !out_valid_reg || m_tready;
        adv       = !(hold_valid_reg && !o_free);
        tok_out   = g_reg.valid && g_reg.fire;
        tok_end   = g_reg.valid && g_reg.fin;
        // a held result leaves once we know whether it closes its step
        hold_mv   = o_free && hold_valid_reg && (hold_fin_reg || tok_out || tok_end);
        hold_last = hold_fin_reg || !tok_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg.valid    <= 1'b0;
            d_reg.valid    <= 1'b0;
            e_reg.valid    <= 1'b0;
            f_reg.valid    <= 1'b0;
            g_reg.valid    <= 1'b0;
        end else if (adv) begin
            c_reg.valid  <= issue;
            c_reg.fin    <= job_last;
            c_reg.pos    <= cur_pos;
            c_reg.newest <= job.newest;
            c_reg.start  <= tok_start;
            c_reg.stop   <= tok_stop;
            c_reg.line   <= job.line;
            d_reg        <= d_next;
            e_reg        <= e_next;
            f_reg        <= f_next;
            g_reg        <= g_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            hold_fin_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (adv && tok_out) begin
                hold_valid_reg <= 1'b1;
                hold_fin_reg   <= tok_end;
            end else if (hold_mv) begin
                hold_valid_reg <= 1'b0;
            end
            if (hold_mv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tok_out) begin
            hold_val_reg <= tok_val;
            hold_pos_reg <= g_reg.pos;
        end
        if (hold_mv) begin
            out_val_reg  <= hold_val_reg;
            out_pos_reg  <= hold_pos_reg;
            out_last_reg <= hold_last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_filtered = out_val_reg;
    assign m_position = out_pos_reg;
    assign m_tlast    = out_last_reg;

endmodule

>>> rtl/core/gated_zero_skip_moving_average_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata[15:0] sample
// m_        out  m_tvalid/m_tready  m_tdata[15:0] filtered, [27:16] position; m_tlast
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// Input takes one sample a cycle while the job queue has room.
// The back end settles one frame position a cycle in its bound sequencer while
// not stalled, so a frame-end sample settles up to three positions there; others one or none.
// Results pass the queue, the c, d, e, f and g stage registers, hold and output to m_tvalid.
// aresetn is synchronous, active low; configuration registers return to their defaults.
// A stalled m_ side fills the hold stage, then the queue, then drops s_tready.

module gated_zero_skip_moving_average_unit import zsma_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // sample request
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,    // [15:0] sample
    // result request
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,    // [15:0] filtered, [27:16] position, zero pad
    output logic                  m_tlast,
    // register writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // live register set
    logic [POS_W-1:0]  frame_len_reg;
    logic [DROP_W-1:0] drop_count_reg;
    logic [POS_W-1:0]  block_len_reg;
    logic [MINV_W-1:0] min_valid_reg;
    // registered write strobe: block bounds reload from the new values at frame start
    logic              cfg_upd_reg;
    cfg_t              cfg;

    job_t                q_in, q_out;
    logic                q_push, q_pop, q_full, q_not_empty;
    logic                idx_zero;
    logic [SAMPLE_W-1:0] filtered;
    logic [POS_W-1:0]    position;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_len_reg  <= RST_FRAME_LEN;
            drop_count_reg <= RST_DROP_COUNT;
            block_len_reg  <= RST_BLOCK_LEN;
            min_valid_reg  <= RST_MIN_VALID;
            cfg_upd_reg    <= 1'b0;
        end else begin
            cfg_upd_reg <= cfg_wr_en;
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_FRAME_LEN:  frame_len_reg  <= cfg_wdata[POS_W-1:0];
                    REG_DROP_COUNT: drop_count_reg <= cfg_wdata[DROP_W-1:0];
                    REG_BLOCK_LEN:  block_len_reg  <= cfg_wdata[POS_W-1:0];
                    REG_MIN_VALID:  min_valid_reg  <= cfg_wdata[MINV_W-1:0];
                endcase
            end
        end
    end

    assign cfg.frame_len  = frame_len_reg;
    assign cfg.drop_count = drop_count_reg;
    assign cfg.block_len  = block_len_reg;
    assign cfg.min_valid  = min_valid_reg;

    // front: frame counting, window line, job classification
    zsma_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_sample (s_tdata[SAMPLE_W-1:0]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in),
        .idx_zero (idx_zero)
    );

    // decouples the sample rate from frame-end flushes and output stalls
    zsma_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    // back: block bounds, window average, reciprocal divide, tlast resolve
    zsma_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cfg_upd    (cfg_upd_reg),
        .idx_zero   (idx_zero),
        .job        (q_out),
        .job_valid  (q_not_empty),
        .job_pop    (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_filtered (filtered),
        .m_position (position),
        .m_tlast    (m_tlast)
    );

    assign m_tdata = {4'b0000, position, filtered};

endmodule

>>> rtl/core/zsma_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zsma_checker import zsma_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [15:0]           s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [31:0]           m_tdata,
    input logic                  m_tlast,
    input logic                  cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_wdata
);

    // reset empties queue and output stage
    `ZSMA_ASSERT_NXT(a_reset_quiet, aclk, 1'b0, !aresetn, s_tready && !m_tvalid, "not idle after reset")

    // a stalled result keeps its value
    `ZSMA_ASSERT_NXT(a_out_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed under stall")

    // a result lies inside a block, so never at the top frame position
    `ZSMA_ASSERT_IMP(a_pos_range, aclk, !aresetn, m_tvalid, m_tdata[27:16] != 12'hFFF, "position out of range")

endmodule

bind gated_zero_skip_moving_average_unit zsma_checker u_zsma_checker (.*);

>>> test/gated_zero_skip_moving_average_unit_tb.sv
`timescale 1ns / 1ps

import zsma_pkg::*;

// one expected result; filtered kept as raw bits, printed signed
typedef struct packed {
    logic              last;
    logic [POS_W-1:0]  position;
    logic [SAMPLE_W-1:0] filtered;
} avg_result_t;

class window_avg_scoreboard;
    // register copy
    int unsigned frame_len;
    int unsigned drop_count;
    int unsigned block_len;
    int unsigned min_valid;
    // datapath copy
    int          win [LINE_DEPTH];  // newest first
    int unsigned frame_idx;
    int unsigned blk_begin;
    int unsigned blk_finish;

    avg_result_t pending_averages [$];
    int errors;
    int n_samples;
    int n_checked;
    int n_raw;

    function new();
        frame_len  = 32'(RST_FRAME_LEN);
        drop_count = 32'(RST_DROP_COUNT);
        block_len  = 32'(RST_BLOCK_LEN);
        min_valid  = 32'(RST_MIN_VALID);
        foreach (win[k]) win[k] = 0;
        frame_idx  = 0;
        errors     = 0;
        n_samples  = 0;
        n_checked  = 0;
        n_raw      = 0;
        load_first_block();
    endfunction

    function void load_first_block();
        blk_begin  = (drop_count < frame_len) ? drop_count : frame_len;
        blk_finish = blk_begin + block_len;
        if (blk_finish > frame_len) blk_finish = frame_len;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_FRAME_LEN:  frame_len  = 32'(val);
            REG_DROP_COUNT: drop_count = 32'(val[DROP_W-1:0]);
            REG_BLOCK_LEN:  block_len  = 32'(val);
            REG_MIN_VALID:  min_valid  = 32'(val[MINV_W-1:0]);
        endcase
        if (frame_idx == 0) load_first_block();
    endfunction

    // decide frame position p; newest is the position of win[0]
    function bit settle_position(int unsigned p, int unsigned newest, output int avg);
        int unsigned out_end;
        int unsigned lo;
        int unsigned hi;
        int unsigned q;
        int          sum;
        int          cnt;
        int          raw;
        avg = 0;
        // step to the next block once p runs past the current one
        if (p >= blk_finish) begin
            blk_begin = blk_finish + drop_count;
            if (blk_begin > frame_len) blk_begin = frame_len;
            blk_finish = blk_begin + block_len;
            if (blk_finish > frame_len) blk_finish = frame_len;
        end
        out_end = (blk_finish > blk_begin && blk_finish - blk_begin > drop_count)
                  ? blk_finish - drop_count : blk_begin;
        if (p < blk_begin || p >= out_end) return 0;
        raw = win[newest - p];
        if (raw == 0) return 0;
        lo  = (p >= HALF_SPAN) ? p - HALF_SPAN : 0;
        hi  = (p + HALF_SPAN < newest) ? p + HALF_SPAN : newest;
        sum = 0;
        cnt = 0;
        for (q = lo; q <= hi; q++) begin
            if (win[newest - q] != 0) begin
                sum += win[newest - q];
                cnt++;
            end
        end
        if (cnt >= min_valid && cnt != 0) begin
            avg = sum / cnt;
        end else begin
            avg = raw;
            n_raw++;
        end
        return 1;
    endfunction

    // accepted sample request: shift the line, queue what it settles
    function void take_sample(logic [SAMPLE_W-1:0] smp);
        int unsigned i;
        int unsigned lo;
        int unsigned hi;
        int unsigned p;
        bit          frame_end;
        int          avg;
        int          n;
        avg_result_t found [3];
        i         = frame_idx;
        frame_end = (i + 1 >= frame_len);
        n         = 0;
        for (int k = LINE_DEPTH - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = int'($signed(smp));
        if (frame_end) begin
            lo = (i >= HALF_SPAN) ? i - HALF_SPAN : 0;
            hi = i;
        end else begin
            lo = (i >= HALF_SPAN) ? i - HALF_SPAN : 0;
            hi = lo;
        end
        if (frame_end || i >= HALF_SPAN) begin
            for (p = lo; p <= hi; p++) begin
                if (settle_position(p, i, avg)) begin
                    found[n].last     = 1'b0;
                    found[n].position = p[POS_W-1:0];
                    found[n].filtered = avg[SAMPLE_W-1:0];
                    n++;
                end
            end
        end
        if (n > 0) found[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) pending_averages.push_back(found[k]);
        if (frame_end) begin
            frame_idx = 0;
            load_first_block();
        end else begin
            frame_idx = (i + 1) & 12'hFFF;
        end
        n_samples++;
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_average(logic [SAMPLE_W-1:0] filtered, logic [POS_W-1:0] position,
                       logic last);
        avg_result_t want;
        n_checked++;
        if (pending_averages.size() == 0) begin
            report($sformatf("unexpected result pos %0d filtered %0d",
                             position, $signed(filtered)));
        end else begin
            want = pending_averages.pop_front();
            if (filtered !== want.filtered)
                report($sformatf("pos %0d filtered got %0d want %0d", want.position,
                                 $signed(filtered), $signed(want.filtered)));
            if (position !== want.position)
                report($sformatf("position got %0d want %0d", position, want.position));
            if (last !== want.last)
                report($sformatf("pos %0d last got %b want %b", want.position,
                                 last, want.last));
        end
    endtask
endclass

module gated_zero_skip_moving_average_unit_tb;

    localparam int RAND_ITEMS     = 100;
    localparam int SETTLE_CYCLES  = 20;    // well past the output pipeline depth plus frame flush
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request moving on either side

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    window_avg_scoreboard sb = new();

    bit calm       = 1'b0;  // set for the closing phase: no idling on either side
    int n_settings = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    // opening run at the reset settings; position 15 sees a window pinned at +full scale
    logic [15:0] opening_run [0:17];

    gated_zero_skip_moving_average_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side back-pressure: m_tready drops at random, in bursts,
    // changed on the falling edge so the DUT sees it settled.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 4);
        end
        m_tready <= (stall_left == 0);
    end

    // Result monitor: every accepted result request is checked in order.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_average(m_tdata[15:0], m_tdata[27:16], m_tlast);
    end

    // Watchdog: a run that stops moving requests is a failure.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress, %0d results still outstanding",
                         sb.pending_averages.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Sample mix: plenty of zeros (skipped points), both full-scale ends,
    // small values near zero and fully random words.
    function automatic logic [15:0] pick_sample();
        int          sel;
        logic [15:0] v;
        sel = $urandom_range(0, 15);
        if (sel < 4)       v = 16'h0000;
        else if (sel == 4) v = 16'h7FFF;
        else if (sel == 5) v = 16'h8000;
        else if (sel < 9)  v = 16'(int'($urandom_range(0, 600)) - 300);
        else               v = 16'($urandom);
        return v;
    endfunction

    // One sample request. Entered and left on a falling edge; tvalid is left
    // high, and outside the calm phase a random idle gap may drop it before a request.
    task automatic send_sample(input logic [15:0] value);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_sample(value);
        @(negedge aclk);
    endtask

    // Hold the sender until every expected result is out, then give the
    // back end time to finish positions that produce nothing.
    task automatic drain_and_hold();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending_averages.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic drive_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    // Writes all four registers, one per cycle; only called with the block idle.
    task automatic apply_config(input logic [CFG_DATA_W-1:0] fl, input logic [CFG_DATA_W-1:0] dc,
                                input logic [CFG_DATA_W-1:0] bl, input logic [CFG_DATA_W-1:0] mv);
        drive_reg(REG_FRAME_LEN, fl);
        drive_reg(REG_DROP_COUNT, dc);
        drive_reg(REG_BLOCK_LEN, bl);
        drive_reg(REG_MIN_VALID, mv);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Mostly short frames and blocks so frame ends and block edges come often;
    // now and then the register extremes.
    task automatic random_config();
        logic [CFG_DATA_W-1:0] fl;
        logic [CFG_DATA_W-1:0] dc;
        logic [CFG_DATA_W-1:0] bl;
        logic [CFG_DATA_W-1:0] mv;
        case ($urandom_range(0, 9))
            0:       fl = CFG_DATA_W'($urandom_range(1, 4));
            1:       fl = 12'd4095;
            default: fl = CFG_DATA_W'($urandom_range(5, 30));
        endcase
        case ($urandom_range(0, 9))
            0:       dc = 12'd255;
            default: dc = CFG_DATA_W'($urandom_range(0, 4));
        endcase
        case ($urandom_range(0, 9))
            0:       bl = 12'd0;
            1:       bl = 12'd4095;
            default: bl = CFG_DATA_W'($urandom_range(1, 12));
        endcase
        mv = CFG_DATA_W'($urandom_range(0, 7));
        apply_config(fl, dc, bl, mv);
    endtask

    task automatic run_phase(input int count);
        for (int k = 0; k < count; k++) begin
            send_sample(pick_sample());
            // occasional full drain with the sender held off
            if (!calm && $urandom_range(0, 39) == 0) drain_and_hold();
        end
    endtask

    initial begin
        int rand_items;
        int len;
        opening_run = '{16'h0001, 16'hFFFF, 16'h0000, 16'h0064, 16'hFF9C, 16'h0000,
                        16'h0007, 16'h0000, 16'h0000, 16'h0000, 16'h0005, 16'h0003,
                        16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};

        // reset: held low, then released on a falling edge
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed part ---
        // reset settings: first kept position is 15
        foreach (opening_run[k]) send_sample(opening_run[k]);
        drain_and_hold();
        // frame length cut below the current index: the next sample ends the
        // frame and flushes three pending positions with one job
        apply_config(12'd4, 12'd15, 12'd250, 12'd3);
        send_sample(16'h8000);
        drain_and_hold();
        // one-sample frames, min valid zero: each nonzero sample is its own average
        apply_config(12'd1, 12'd0, 12'd1, 12'd0);
        send_sample(16'h8000);
        send_sample(16'h0000);
        drain_and_hold();
        // frame length zero: every sample is a frame, nothing comes out
        apply_config(12'd0, 12'd0, 12'd1, 12'd1);
        send_sample(16'h3039);
        drain_and_hold();
        // block length zero, min valid above the window
        apply_config(12'd6, 12'd1, 12'd0, 12'd6);
        run_phase(6);
        drain_and_hold();
        // widest frame and block, no drops
        apply_config(12'd4095, 12'd0, 12'd4095, 12'd5);
        run_phase(12);
        drain_and_hold();
        // widest drop mid-frame: bounds only reload at the next frame start
        apply_config(12'd4095, 12'd255, 12'd4095, 12'd7);
        run_phase(6);

        // --- random part ---
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            drain_and_hold();
            random_config();
            len = $urandom_range(10, 36);
            run_phase(len);
            rand_items += len;
        end

        // closing phase without idling on either side
        drain_and_hold();
        calm = 1'b1;
        random_config();
        run_phase(20);

        s_tvalid <= 1'b0;
        while (sb.pending_averages.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d samples sent over %0d register settings; %0d results compared",
                 sb.n_samples, n_settings, sb.n_checked);
        $display("%0d results fell back to the raw sample; %0d mismatches",
                 sb.n_raw, sb.errors);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> gated_zero_skip_moving_average_unit.f
+incdir+rtl/core
rtl/core/zsma_pkg.sv
rtl/core/zsma_queue.sv
rtl/core/zsma_front.sv
rtl/core/zsma_back.sv
rtl/core/gated_zero_skip_moving_average_unit.sv
rtl/core/zsma_checker.sv
test/gated_zero_skip_moving_average_unit_tb.sv
